// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the job slot table.
// Depends on nothing; every user supplies clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked implication, off while reset is asserted.
`define ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

// ===== sv/pjst_pkg.sv =====
// Shared types and constants of the job slot table.
// No dependencies.
`default_nettype none
package pjst_pkg;
	localparam int MAX_JOBS_DEF = 16;
	localparam int MAX_RESULTS  = 16;
	localparam int RES_W        = 5;
	localparam logic [15:0] TAG_VALUE = 16'hbeef;

	localparam logic [2:0] ACT_REGISTER   = 3'd0;
	localparam logic [2:0] ACT_UNREGISTER = 3'd1;
	localparam logic [2:0] ACT_ENABLE     = 3'd2;
	localparam logic [2:0] ACT_DISABLE    = 3'd3;
	localparam logic [2:0] ACT_EXECUTE    = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_BAD     = 3'd2;
	localparam logic [2:0] ST_NOT_REG = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] prio;
		logic [5:0]  slot;
		logic        bad;
	} pjst_cmd_t;
endpackage
`default_nettype wire

// ===== sv/pjst_req_if.sv =====
// Request channel of the job slot table: valid/ready plus command fields.
// No dependencies.
`default_nettype none
interface pjst_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [31:0] priority_req;
	logic [31:0] handle;
	modport source (output valid, action, priority_req, handle, input ready);
	modport sink (input valid, action, priority_req, handle, output ready);
endinterface
`default_nettype wire

// ===== sv/pjst_rsp_if.sv =====
// Response channel of the job slot table: valid/ready plus result fields.
// No dependencies.
`default_nettype none
interface pjst_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] handle_out;
	logic [5:0]  slot_index;
	logic [2:0]  status;
	logic        last;
	modport source (output valid, handle_out, slot_index, status, last, input ready);
	modport sink (input valid, handle_out, slot_index, status, last, output ready);
endinterface
`default_nettype wire

// ===== sv/pjst_front.sv =====
// Front end: accepts requests, checks handles, queues commands (2 deep).
// Depends on pjst_pkg and pjst_req_if.
`default_nettype none
module pjst_front #(
	parameter int MAX_JOBS = pjst_pkg::MAX_JOBS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	pjst_req_if.sink          req,
	output logic              cmd_valid,
	output pjst_pkg::pjst_cmd_t cmd,
	input  logic              cmd_ready
);
	import pjst_pkg::*;

	pjst_cmd_t  q_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	pjst_cmd_t  new_cmd;

	assign req.ready = (cnt_q != 2'd2);
	// drop unknown actions: they give no result
	assign push = req.valid && req.ready && (req.action <= ACT_EXECUTE);
	assign pop  = cmd_valid && cmd_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rd_ptr_q];

	always_comb begin
		new_cmd.action = req.action;
		new_cmd.prio   = req.priority_req;
		new_cmd.slot   = req.handle[5:0];
		new_cmd.bad    = (req.handle[31:16] != TAG_VALUE) ||
			(req.handle[15:0] >= 16'(MAX_JOBS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= new_cmd;
		end
	end
endmodule
`default_nettype wire

// ===== sv/pjst_back.sv =====
// Back end: slot state, command execution, execute dispatch, result register.
// Depends on pjst_pkg, pjst_rsp_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module pjst_back #(
	parameter int MAX_JOBS = pjst_pkg::MAX_JOBS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  pjst_pkg::pjst_cmd_t cmd,
	output logic              cmd_ready,
	pjst_rsp_if.source        rsp
);
	import pjst_pkg::*;

	localparam int SW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);

	typedef enum logic [2:0] {S_IDLE, S_COUNT, S_SCAN, S_EMIT} state_t;

	state_t         state_q;
	logic [31:0]    prio_q [MAX_JOBS];
	logic [SW-1:0]  free_q [MAX_JOBS];
	logic [SW-1:0]  used_q [MAX_JOBS];
	logic [CW-1:0]  free_cnt_q, used_cnt_q;
	logic [CW-1:0]  idx_q, en_cnt_q;
	logic [RES_W-1:0] lim_q, emitted_q;
	logic           found_q, have_last_q;
	logic [31:0]    best_p_q, last_p_q;
	logic [CW-1:0]  best_pos_q, last_pos_q;
	logic [SW-1:0]  best_s_q;
	logic           out_valid_q;
	logic [31:0]    out_handle_q;
	logic [5:0]     out_slot_q;
	logic [2:0]     out_status_q;
	logic           out_last_q;

	logic           out_free;
	logic [CW-1:0]  fcm1;
	logic [SW-1:0]  cur_s, cmd_s, new_s;
	logic [31:0]    cur_p;
	logic           cur_in, cand, hit;
	logic [CW-1:0]  hit_pos;
	logic           reg_full, emit_end;
	logic           out_load;
	logic [31:0]    out_handle_d;
	logic [5:0]     out_slot_d;
	logic [2:0]     out_status_d;
	logic           out_last_d;

	assign out_free   = !out_valid_q || rsp.ready;
	assign cmd_ready  = (state_q == S_IDLE) && out_free;
	assign rsp.valid  = out_valid_q;
	assign rsp.handle_out = out_handle_q;
	assign rsp.slot_index = out_slot_q;
	assign rsp.status = out_status_q;
	assign rsp.last   = out_last_q;

	assign fcm1  = free_cnt_q - CW'(1);
	assign new_s = free_q[fcm1[SW-1:0]];
	assign reg_full = (free_cnt_q == '0) || (used_cnt_q >= CW'(MAX_JOBS));
	assign emit_end = (emitted_q + RES_W'(1) == lim_q);
	assign cmd_s = cmd.slot[SW-1:0];
	assign cur_in = (idx_q < used_cnt_q);
	assign cur_s = used_q[idx_q[SW-1:0]];
	assign cur_p = prio_q[cur_s];
	// candidate comes strictly after the last emitted job in (priority, position) order
	assign cand = !cur_p[31] && (!have_last_q || (cur_p > last_p_q) ||
		((cur_p == last_p_q) && (idx_q > last_pos_q)));

	always_comb begin
		hit = 1'b0;
		hit_pos = '0;
		for (int i = MAX_JOBS - 1; i >= 0; i--) begin
			if ((CW'(i) < used_cnt_q) && (used_q[i] == cmd_s)) begin
				hit = 1'b1;
				hit_pos = CW'(i);
			end
		end
	end

	// result register load: one source per state
	always_comb begin
		out_load     = 1'b0;
		out_handle_d = '0;
		out_slot_d   = '0;
		out_status_d = ST_OK;
		out_last_d   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid && out_free && (cmd.action != ACT_EXECUTE)) begin
					out_load = 1'b1;
					if (cmd.action == ACT_REGISTER) begin
						if (reg_full) begin
							out_status_d = ST_FULL;
						end else begin
							out_handle_d = {TAG_VALUE, 16'(new_s)};
							out_slot_d   = 6'(new_s);
						end
					end else if (cmd.bad) begin
						out_status_d = ST_BAD;
					end else begin
						out_slot_d = cmd.slot;
						if ((cmd.action == ACT_UNREGISTER) && !hit) begin
							out_status_d = ST_NOT_REG;
						end
					end
				end
			end
			S_COUNT: begin
				if (!cur_in && (en_cnt_q == '0) && out_free) begin
					out_load     = 1'b1;
					out_status_d = ST_EMPTY;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_slot_d = 6'(best_s_q);
					out_last_d = emit_end;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			out_handle_q <= '0;
			out_slot_q   <= '0;
			out_status_q <= ST_OK;
			out_last_q   <= 1'b0;
			free_cnt_q   <= CW'(MAX_JOBS);
			used_cnt_q   <= '0;
			for (int i = 0; i < MAX_JOBS; i++) begin
				free_q[i] <= SW'(i);
			end
		end else begin
			out_valid_q <= out_load || (out_valid_q && !rsp.ready);
			if (out_load) begin
				out_handle_q <= out_handle_d;
				out_slot_q   <= out_slot_d;
				out_status_q <= out_status_d;
				out_last_q   <= out_last_d;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid && out_free) begin
						if (cmd.action == ACT_REGISTER) begin
							if (!reg_full) begin
								free_cnt_q <= fcm1;
								prio_q[new_s] <= cmd.prio;
								used_q[used_cnt_q[SW-1:0]] <= new_s;
								used_cnt_q <= used_cnt_q + CW'(1);
							end
						end else if (cmd.action == ACT_EXECUTE) begin
							idx_q    <= '0;
							en_cnt_q <= '0;
							state_q  <= S_COUNT;
						end else if (!cmd.bad) begin
							if (cmd.action == ACT_UNREGISTER) begin
								if (hit) begin
									// close the gap, keep order
									for (int i = 0; i < MAX_JOBS - 1; i++) begin
										if ((CW'(i) >= hit_pos) && (CW'(i + 1) < used_cnt_q)) begin
											used_q[i] <= used_q[i + 1];
										end
									end
									used_cnt_q <= used_cnt_q - CW'(1);
									if (free_cnt_q < CW'(MAX_JOBS)) begin
										free_q[free_cnt_q[SW-1:0]] <= cmd_s;
										free_cnt_q <= free_cnt_q + CW'(1);
									end
								end
							end else if (cmd.action == ACT_ENABLE) begin
								prio_q[cmd_s][31] <= 1'b0;
							end else begin
								prio_q[cmd_s][31] <= 1'b1;
							end
						end
					end
				end
				S_COUNT: begin
					if (cur_in) begin
						if (!cur_p[31]) begin
							en_cnt_q <= en_cnt_q + CW'(1);
						end
						idx_q <= idx_q + CW'(1);
					end else if (en_cnt_q == '0) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						lim_q <= (32'(en_cnt_q) > MAX_RESULTS) ? RES_W'(MAX_RESULTS)
							: RES_W'(en_cnt_q);
						emitted_q   <= '0;
						have_last_q <= 1'b0;
						found_q     <= 1'b0;
						idx_q       <= '0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cur_in) begin
						if (cand && (!found_q || cur_p < best_p_q)) begin
							found_q    <= 1'b1;
							best_p_q   <= cur_p;
							best_pos_q <= idx_q;
							best_s_q   <= cur_s;
						end
						idx_q <= idx_q + CW'(1);
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						emitted_q    <= emitted_q + RES_W'(1);
						last_p_q     <= best_p_q;
						last_pos_q   <= best_pos_q;
						have_last_q  <= 1'b1;
						found_q      <= 1'b0;
						idx_q        <= '0;
						state_q      <= emit_end ? S_IDLE : S_SCAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_count_sum, (32'(free_cnt_q) + 32'(used_cnt_q) == MAX_JOBS), "slot count mismatch")
	`ASSERT_IMP(a_emit_found, state_q == S_EMIT, found_q, "dispatch without a selected job")
	`ASSERT_IMP(a_emit_lim, (state_q == S_SCAN) || (state_q == S_EMIT), emitted_q < lim_q, "dispatch past limit")
endmodule
`default_nettype wire

// ===== sv/priority_job_slot_table.sv =====
// Top level of the job slot table: front end, command queue, back end.
// Depends on pjst_pkg, pjst_req_if, pjst_rsp_if, pjst_front, pjst_back.
//
//  channel | dir | transaction carries
//  req     | in  | action, priority_req, handle
//  rsp     | out | handle_out, slot_index, status, last
//
// Control commands pass through the queue, then are executed by the back end in S_IDLE.
// Execute scans the used list once to count the enabled jobs, then once per
// emitted job.
// Reset clears the free stack to 0..MAX_JOBS-1 and empties the used list.
// A stalled rsp holds the back end; the 2-deep queue keeps req open until it is full.
`default_nettype none
module priority_job_slot_table #(
	parameter int MAX_JOBS = pjst_pkg::MAX_JOBS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pjst_req_if.sink    req,
	pjst_rsp_if.source  rsp
);
	import pjst_pkg::*;

	logic      cmd_valid, cmd_ready;
	pjst_cmd_t cmd;

	pjst_front #(.MAX_JOBS(MAX_JOBS)) u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready)
	);

	pjst_back #(.MAX_JOBS(MAX_JOBS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready), .rsp(rsp)
	);
endmodule
`default_nettype wire
